[rtl/core/spq_pkg.sv]
// Shared types and constants of the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned IN_PRIO_W   = 8;
  localparam int unsigned OCCUPANCY_W = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_e;

  typedef struct packed {
    logic en;
    op_e  op;
  } cell_ctl_t;

endpackage

[rtl/core/spq_if.sv]
// Valid/ready channel interfaces for the queue command and result beats.
`timescale 1ns / 1ps

interface spq_in_if;
  logic                                 valid;
  logic                                 ready;
  spq_pkg::op_e                         op;
  logic signed [spq_pkg::VALUE_W-1:0]   item_value;
  logic        [spq_pkg::IN_PRIO_W-1:0] item_priority;

  modport source (output valid, op, item_value, item_priority, input ready);
  modport sink   (input valid, op, item_value, item_priority, output ready);
endinterface

interface spq_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [spq_pkg::VALUE_W-1:0]     popped_value;
  logic                                   popped_valid;
  logic                                   overflow_error;
  logic                                   underflow_error;
  logic        [spq_pkg::OCCUPANCY_W-1:0] occupancy;

  modport source (output valid, popped_value, popped_valid, overflow_error,
                  underflow_error, occupancy, input ready);
  modport sink   (input valid, popped_value, popped_valid, overflow_error,
                  underflow_error, occupancy, output ready);
endinterface

[rtl/core/spq_cell.sv]
// One storage cell of the sorted chain: holds an entry, shifts left or right.
`timescale 1ns / 1ps

module spq_cell #(
  parameter int unsigned PRIO_W = 8
) (
  input  logic                               clk_i,
  input  spq_pkg::cell_ctl_t                 ctl_i,
  input  logic                               occ_i,
  input  logic signed [spq_pkg::VALUE_W-1:0] ins_value_i,
  input  logic        [PRIO_W-1:0]           ins_prio_i,
  input  logic                               left_keep_i,
  input  logic signed [spq_pkg::VALUE_W-1:0] left_value_i,
  input  logic        [PRIO_W-1:0]           left_prio_i,
  input  logic signed [spq_pkg::VALUE_W-1:0] right_value_i,
  input  logic        [PRIO_W-1:0]           right_prio_i,
  output logic                               keep_o,
  output logic signed [spq_pkg::VALUE_W-1:0] value_o,
  output logic        [PRIO_W-1:0]           prio_o
);
  import spq_pkg::*;

  logic signed [VALUE_W-1:0] value_q, value_d;
  logic        [PRIO_W-1:0]  prio_q, prio_d;

  assign keep_o  = occ_i && (prio_q <= ins_prio_i);
  assign value_o = value_q;
  assign prio_o  = prio_q;

  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    if (ctl_i.en) begin
      if (ctl_i.op == OP_POP) begin
        value_d = right_value_i;
        prio_d  = right_prio_i;
      end else if (!keep_o) begin
        if (left_keep_i) begin
          value_d = ins_value_i;
          prio_d  = ins_prio_i;
        end else begin
          value_d = left_value_i;
          prio_d  = left_prio_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

endmodule

[rtl/core/sorted_priority_queue.sv]
// Top level of the sorted priority queue built from a chain of cells.
//
// Usage:
//   in_i carries command beats: op selects insert or pop, item_value and
//   item_priority give the entry for an insert. out_o returns one result
//   beat per command: the popped data word and its flag, the overflow and
//   underflow flags, and the occupancy after the command.
//   Entries leave in ascending priority number, equal priorities in arrival
//   order. An insert into a full queue is dropped; a pop of an empty queue
//   changes nothing.
//   The result beat is registered and appears in the cycle after its command
//   beat is taken. Throughput: one command per cycle while out_o.ready takes
//   each result beat. Every cell of the chain compares its priority with the
//   new one in parallel and shifts in the same cycle. A full result register
//   that is not taken holds in_i.ready low until out_o.ready takes it; the
//   command is never lost. Reset empties the queue and the result register;
//   stored words need no clearing since only occupied cells are ever read.
`timescale 1ns / 1ps

module sorted_priority_queue #(
  parameter int unsigned CAPACITY      = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]          count_q, count_d;
  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] popped_value_q, popped_value_d;
  logic                      popped_valid_q, popped_valid_d;
  logic                      overflow_q, overflow_d;
  logic                      underflow_q, underflow_d;

  logic                      accept;
  logic                      full;
  logic                      empty;
  logic [PRIORITY_BITS-1:0]  ins_prio;
  cell_ctl_t                 ctl;

  logic                      keep      [CAPACITY];
  logic signed [VALUE_W-1:0] cell_value[CAPACITY];
  logic [PRIORITY_BITS-1:0]  cell_prio [CAPACITY];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign empty      = (count_q == '0);
  assign ins_prio   = PRIORITY_BITS'(in_i.item_priority);

  assign ctl.op = in_i.op;
  assign ctl.en = accept && ((in_i.op == OP_INSERT) ? !full : !empty);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      left_keep;
    logic signed [VALUE_W-1:0] left_value;
    logic [PRIORITY_BITS-1:0]  left_prio;
    logic signed [VALUE_W-1:0] right_value;
    logic [PRIORITY_BITS-1:0]  right_prio;

    if (i == 0) begin : g_head
      assign left_keep  = 1'b1;
      assign left_value = in_i.item_value;
      assign left_prio  = ins_prio;
    end else begin : g_mid
      assign left_keep  = keep[i-1];
      assign left_value = cell_value[i-1];
      assign left_prio  = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[i];
      assign right_prio  = cell_prio[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_prio  = cell_prio[i+1];
    end

    spq_cell #(
      .PRIO_W (PRIORITY_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .occ_i         (CNT_W'(i) < count_q),
      .ins_value_i   (in_i.item_value),
      .ins_prio_i    (ins_prio),
      .left_keep_i   (left_keep),
      .left_value_i  (left_value),
      .left_prio_i   (left_prio),
      .right_value_i (right_value),
      .right_prio_i  (right_prio),
      .keep_o        (keep[i]),
      .value_o       (cell_value[i]),
      .prio_o        (cell_prio[i])
    );
  end

  always_comb begin
    count_d        = count_q;
    popped_value_d = '0;
    popped_valid_d = 1'b0;
    overflow_d     = 1'b0;
    underflow_d    = 1'b0;
    if (in_i.op == OP_INSERT) begin
      if (full) begin
        overflow_d = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        underflow_d = 1'b1;
      end else begin
        count_d        = count_q - CNT_W'(1);
        popped_value_d = cell_value[0];
        popped_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_value_q <= popped_value_d;
      popped_valid_q <= popped_valid_d;
      overflow_q     <= overflow_d;
      underflow_q    <= underflow_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.popped_value    = popped_value_q;
  assign out_o.popped_valid    = popped_valid_q;
  assign out_o.overflow_error  = overflow_q;
  assign out_o.underflow_error = underflow_q;
  assign out_o.occupancy       = OCCUPANCY_W'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.op == OP_POP && !empty |=>
      out_valid_q && popped_valid_q && count_q == $past(count_q) - CNT_W'(1))
    else $error("pop of a stored entry gave no popped word");

  a_overflow_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.op == OP_INSERT && full |=> overflow_q && $stable(count_q))
    else $error("insert into full queue changed the store");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $countones({popped_valid_q, overflow_q, underflow_q}) <= 1)
    else $error("conflicting result flags");

endmodule
